@@ hdl/tgq_pkg.sv @@
`default_nettype none

package tgq_pkg;

  localparam int REQ_W  = 2;
  localparam int ELEM_W = 10;
  localparam int TEAM_W = 8;
  localparam int ST_W   = 2;

  localparam logic [REQ_W-1:0] REQ_ASSIGN = 2'd0;
  localparam logic [REQ_W-1:0] ENQUEUE    = 2'd1;
  localparam logic [REQ_W-1:0] DEQUEUE    = 2'd2;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd3;

  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

`default_nettype wire

@@ hdl/tgq_ram.sv @@
`default_nettype none

module tgq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read-first on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ hdl/team_grouped_queue_unit.sv @@
`default_nettype none
// Each word is accepted in S_IDLE; its result word goes to the output register from
// S_DONE. Enqueue first passes S_ENQ_TEAM, S_ENQ_LAST and S_ENQ_LINK, dequeue
// S_DEQ_READ and S_DEQ_TEAM; assign, clear and rejects go straight to S_DONE.
// One word at a time: the next word is taken only back in S_IDLE, and S_DONE waits
// while a result sits in the stalled output register; the sequencer walking the
// registered RAMs, each with one write and one read port, sets this. Reset is
// asynchronous; afterwards the membership RAM is swept to zero while in_stall_o stays high.

module team_grouped_queue_unit #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int MAX_TEAMS    = 256,
  parameter int CAPACITY     = 256
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [tgq_pkg::REQ_W-1:0]   req_type_i,
  input  wire logic [tgq_pkg::ELEM_W-1:0]  element_id_i,
  input  wire logic [tgq_pkg::TEAM_W-1:0]  team_id_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic      [tgq_pkg::ELEM_W-1:0]  out_element_o,
  output logic      [tgq_pkg::ST_W-1:0]    status_o
);

  import tgq_pkg::*;

  localparam int EL_AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int TM_AW = (MAX_TEAMS > 1) ? $clog2(MAX_TEAMS) : 1;
  localparam int SL_W  = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_INIT     = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_ENQ_TEAM = 3'd2;
  localparam logic [2:0] S_ENQ_LAST = 3'd3;
  localparam logic [2:0] S_ENQ_LINK = 3'd4;
  localparam logic [2:0] S_DEQ_READ = 3'd5;
  localparam logic [2:0] S_DEQ_TEAM = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0]           state_q, state_d;
  logic [EL_AW-1:0]     init_q, init_d;
  logic [SL_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic                 head_vld_q, head_vld_d, tail_vld_q, tail_vld_d;
  logic [CNT_W-1:0]     count_q, count_d, fresh_q, fresh_d, sp_q, sp_d;
  logic [MAX_TEAMS-1:0] tls_vld_q, tls_vld_d;
  logic [ELEM_W-1:0]    elem_q, elem_d;
  logic                 elem_ok_q, elem_ok_d, use_fresh_q, use_fresh_d;
  logic [TM_AW-1:0]     team_q, team_d;
  logic [SL_W-1:0]      slot_q, slot_d;
  logic                 link_en_q, link_en_d, link_ram_q, link_ram_d;
  logic [SL_W-1:0]      link_addr_q, link_addr_d;
  logic [ELEM_W-1:0]    res_elem_q, res_elem_d;
  logic [ST_W-1:0]      res_st_q, res_st_d;
  logic                 out_vld_q, out_vld_d;
  logic [ELEM_W-1:0]    out_elem_q, out_elem_d;
  logic [ST_W-1:0]      out_st_q, out_st_d;

  logic                 toe_we;
  logic [EL_AW-1:0]     toe_waddr, toe_raddr;
  logic [TM_AW-1:0]     toe_wdata, toe_rdata;
  logic                 tls_we;
  logic [TM_AW-1:0]     tls_waddr, tls_raddr;
  logic [SL_W-1:0]      tls_wdata, tls_rdata;
  logic                 sel_we;
  logic [SL_W-1:0]      sel_waddr;
  logic [ELEM_W+TM_AW-1:0] sel_wdata, sel_rdata;
  logic                 nxt_we;
  logic [SL_W-1:0]      nxt_waddr, nxt_raddr;
  logic [SL_W:0]        nxt_wdata, nxt_rdata;
  logic                 fr_we;
  logic [SL_W-1:0]      fr_waddr, fr_raddr, fr_wdata, fr_rdata;

  logic [31:0]          elem_ext, team_ext;
  logic                 elem_in, team_in;
  logic [CNT_W-1:0]     sp_m1;
  logic [TM_AW-1:0]     team_n;
  logic [SL_W-1:0]      slot_n;

  assign elem_ext = 32'(element_id_i);
  assign team_ext = 32'(team_id_i);
  assign elem_in  = elem_ext < 32'(MAX_ELEMENTS);
  assign team_in  = team_ext < 32'(MAX_TEAMS);
  assign sp_m1    = sp_q - 1'b1;
  assign team_n   = elem_ok_q ? toe_rdata : '0;
  assign slot_n   = use_fresh_q ? fresh_q[SL_W-1:0] : fr_rdata;

  always_comb begin
    state_d     = state_q;
    init_d      = init_q;
    head_d      = head_q;
    head_vld_d  = head_vld_q;
    tail_d      = tail_q;
    tail_vld_d  = tail_vld_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    sp_d        = sp_q;
    tls_vld_d   = tls_vld_q;
    elem_d      = elem_q;
    elem_ok_d   = elem_ok_q;
    use_fresh_d = use_fresh_q;
    team_d      = team_q;
    slot_d      = slot_q;
    link_en_d   = link_en_q;
    link_ram_d  = link_ram_q;
    link_addr_d = link_addr_q;
    res_elem_d  = res_elem_q;
    res_st_d    = res_st_q;
    out_vld_d   = out_vld_q;
    out_elem_d  = out_elem_q;
    out_st_d    = out_st_q;

    toe_we    = 1'b0;
    toe_waddr = elem_ext[EL_AW-1:0];
    toe_wdata = team_ext[TM_AW-1:0];
    toe_raddr = elem_ext[EL_AW-1:0];
    tls_we    = 1'b0;
    tls_waddr = team_q;
    tls_wdata = slot_q;
    tls_raddr = team_q;
    sel_we    = 1'b0;
    sel_waddr = slot_n;
    sel_wdata = {elem_q, team_n};
    nxt_we    = 1'b0;
    nxt_waddr = slot_q;
    nxt_wdata = {1'b1, slot_q};
    nxt_raddr = head_q;
    fr_we     = 1'b0;
    fr_waddr  = sp_q[SL_W-1:0];
    fr_wdata  = slot_q;
    fr_raddr  = sp_m1[SL_W-1:0];

    if (out_vld_q && !out_stall_i) begin
      out_vld_d = 1'b0;
    end

    unique case (state_q)
      S_INIT: begin
        toe_we    = 1'b1;
        toe_waddr = init_q;
        toe_wdata = '0;
        init_d    = init_q + 1'b1;
        if (init_q == EL_AW'(MAX_ELEMENTS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          elem_d     = element_id_i;
          res_elem_d = '0;
          res_st_d   = ST_OK;
          state_d    = S_DONE;
          unique case (req_type_i)
            REQ_ASSIGN: begin
              toe_we = elem_in && team_in;
            end
            ENQUEUE: begin
              if (count_q == CNT_W'(CAPACITY)) begin
                res_st_d = ST_FULL;
              end else begin
                elem_ok_d   = elem_in;
                use_fresh_d = fresh_q != CNT_W'(CAPACITY);
                state_d     = S_ENQ_TEAM;
              end
            end
            DEQUEUE: begin
              if (count_q == '0) begin
                res_st_d = ST_EMPTY;
              end else begin
                slot_d  = head_q;
                state_d = S_DEQ_READ;
              end
            end
            REQ_CLEAR: begin
              tls_vld_d  = '0;
              head_vld_d = 1'b0;
              tail_vld_d = 1'b0;
              count_d    = '0;
              fresh_d    = '0;
              sp_d       = '0;
            end
            default: ;
          endcase
        end
      end
      S_ENQ_TEAM: begin
        if (use_fresh_q) begin
          fresh_d = fresh_q + 1'b1;
        end else begin
          sp_d = sp_m1;
        end
        team_d    = team_n;
        slot_d    = slot_n;
        sel_we    = 1'b1;
        tls_raddr = team_n;
        state_d   = S_ENQ_LAST;
      end
      S_ENQ_LAST: begin
        if (tls_vld_q[team_q]) begin
          // splice behind the team's last member; old link is read first
          nxt_raddr   = tls_rdata;
          nxt_we      = 1'b1;
          nxt_waddr   = tls_rdata;
          link_en_d   = 1'b1;
          link_ram_d  = 1'b1;
          link_addr_d = slot_q;
          if (tail_vld_q && tls_rdata == tail_q) begin
            tail_d = slot_q;
          end
        end else begin
          nxt_we      = 1'b1;
          nxt_wdata   = '0;
          link_en_d   = tail_vld_q;
          link_ram_d  = 1'b0;
          link_addr_d = tail_q;
          if (!tail_vld_q) begin
            head_d     = slot_q;
            head_vld_d = 1'b1;
          end
          tail_d     = slot_q;
          tail_vld_d = 1'b1;
        end
        tls_we             = 1'b1;
        tls_vld_d[team_q]  = 1'b1;
        count_d            = count_q + 1'b1;
        state_d            = S_ENQ_LINK;
      end
      S_ENQ_LINK: begin
        nxt_we    = link_en_q;
        nxt_waddr = link_addr_q;
        nxt_wdata = link_ram_q ? nxt_rdata : {1'b1, slot_q};
        state_d   = S_DONE;
      end
      S_DEQ_READ: begin
        res_elem_d = sel_rdata[ELEM_W+TM_AW-1:TM_AW];
        team_d     = sel_rdata[TM_AW-1:0];
        tls_raddr  = sel_rdata[TM_AW-1:0];
        if (nxt_rdata[SL_W]) begin
          head_d = nxt_rdata[SL_W-1:0];
        end else begin
          head_vld_d = 1'b0;
          tail_vld_d = 1'b0;
        end
        count_d = count_q - 1'b1;
        fr_we   = 1'b1;
        sp_d    = sp_q + 1'b1;
        state_d = S_DEQ_TEAM;
      end
      S_DEQ_TEAM: begin
        if (tls_vld_q[team_q] && tls_rdata == slot_q) begin
          tls_vld_d[team_q] = 1'b0;
        end
        state_d = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_q || !out_stall_i) begin
          out_vld_d  = 1'b1;
          out_elem_d = res_elem_q;
          out_st_d   = res_st_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_INIT;
      init_q     <= '0;
      head_vld_q <= 1'b0;
      tail_vld_q <= 1'b0;
      count_q    <= '0;
      fresh_q    <= '0;
      sp_q       <= '0;
      tls_vld_q  <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_q     <= init_d;
      head_vld_q <= head_vld_d;
      tail_vld_q <= tail_vld_d;
      count_q    <= count_d;
      fresh_q    <= fresh_d;
      sp_q       <= sp_d;
      tls_vld_q  <= tls_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q      <= head_d;
    tail_q      <= tail_d;
    elem_q      <= elem_d;
    elem_ok_q   <= elem_ok_d;
    use_fresh_q <= use_fresh_d;
    team_q      <= team_d;
    slot_q      <= slot_d;
    link_en_q   <= link_en_d;
    link_ram_q  <= link_ram_d;
    link_addr_q <= link_addr_d;
    res_elem_q  <= res_elem_d;
    res_st_q    <= res_st_d;
    out_elem_q  <= out_elem_d;
    out_st_q    <= out_st_d;
  end

  tgq_ram #(.WIDTH(TM_AW), .DEPTH(MAX_ELEMENTS)) u_toe_ram (
    .clk_i   (clk_i),
    .we_i    (toe_we),
    .waddr_i (toe_waddr),
    .wdata_i (toe_wdata),
    .raddr_i (toe_raddr),
    .rdata_o (toe_rdata)
  );

  tgq_ram #(.WIDTH(SL_W), .DEPTH(MAX_TEAMS)) u_tls_ram (
    .clk_i   (clk_i),
    .we_i    (tls_we),
    .waddr_i (tls_waddr),
    .wdata_i (tls_wdata),
    .raddr_i (tls_raddr),
    .rdata_o (tls_rdata)
  );

  tgq_ram #(.WIDTH(ELEM_W + TM_AW), .DEPTH(CAPACITY)) u_sel_ram (
    .clk_i   (clk_i),
    .we_i    (sel_we),
    .waddr_i (sel_waddr),
    .wdata_i (sel_wdata),
    .raddr_i (head_q),
    .rdata_o (sel_rdata)
  );

  tgq_ram #(.WIDTH(SL_W + 1), .DEPTH(CAPACITY)) u_nxt_ram (
    .clk_i   (clk_i),
    .we_i    (nxt_we),
    .waddr_i (nxt_waddr),
    .wdata_i (nxt_wdata),
    .raddr_i (nxt_raddr),
    .rdata_o (nxt_rdata)
  );

  tgq_ram #(.WIDTH(SL_W), .DEPTH(CAPACITY)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fr_we),
    .waddr_i (fr_waddr),
    .wdata_i (fr_wdata),
    .raddr_i (fr_raddr),
    .rdata_o (fr_rdata)
  );

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = out_vld_q;
  assign out_element_o = out_elem_q;
  assign status_o      = out_st_q;

`ifndef SYNTHESIS
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("queued count above capacity");

  a_head_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> head_vld_q == (count_q != '0))
    else $error("head pointer disagrees with queued count");

  a_tail_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> tail_vld_q == head_vld_q)
    else $error("tail pointer disagrees with head pointer");

  a_slot_books: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |->
      (CNT_W+1)'(sp_q) + (CNT_W+1)'(count_q) == (CNT_W+1)'(fresh_q))
    else $error("free-slot accounting broken");

  a_done_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE && !(out_vld_q && out_stall_i) |=> out_vld_q && state_q == S_IDLE)
    else $error("finished word not delivered to output register");
`endif

endmodule

`default_nettype wire

@@ tb/team_grouped_queue_unit_test.sv @@
module team_grouped_queue_unit_test;
  import tgq_pkg::*;

  localparam int QCAP = 256;
  localparam int NELEM = 1024;
  localparam int PHASE_WORDS = 190;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic [ST_W-1:0]   status;
  } reply_t;

  typedef struct packed {
    logic [ELEM_W-1:0] elem;
    logic [TEAM_W-1:0] team;
  } slot_t;

  typedef struct packed {
    logic [REQ_W-1:0]  req;
    logic [ELEM_W-1:0] elem;
    logic [TEAM_W-1:0] team;
    logic              typed;
    logic [ELEM_W-1:0] exp_elem;
    logic [ST_W-1:0]   exp_st;
  } step_t;

  typedef enum int {MODE_MIX, MODE_FILL, MODE_DRAIN} mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [REQ_W-1:0]  req_type_i = '0;
  logic [ELEM_W-1:0] element_id_i = '0;
  logic [TEAM_W-1:0] team_id_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [ELEM_W-1:0] out_element_o;
  logic [ST_W-1:0]   status_o;

  logic [TEAM_W-1:0] team_of [NELEM];
  slot_t             line_q[$];
  reply_t            owed_replies[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int replies_seen = 0;
  int n_req [4];
  int n_full = 0;
  int n_empty = 0;
  int peak_depth = 0;

  reply_t want;

  team_grouped_queue_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .element_id_i  (element_id_i),
    .team_id_i     (team_id_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_element_o (out_element_o),
    .status_o      (status_o)
  );

  always #4 clk_i = ~clk_i;

  // expected reply, team members kept contiguous in line_q
  function automatic reply_t team_queue_reply(input logic [REQ_W-1:0] req,
                                              input logic [ELEM_W-1:0] elem,
                                              input logic [TEAM_W-1:0] team);
    reply_t r;
    slot_t  s;
    int     pos;
    r = '0;
    r.status = ST_OK;
    case (req)
      REQ_ASSIGN: begin
        team_of[elem] = team;
      end
      ENQUEUE: begin
        if (line_q.size() >= QCAP) begin
          r.status = ST_FULL;
        end else begin
          s.elem = elem;
          s.team = team_of[elem];
          pos = line_q.size();
          for (int i = line_q.size() - 1; i >= 0; i--) begin
            if (line_q[i].team == s.team) begin
              pos = i + 1;
              break;
            end
          end
          line_q.insert(pos, s);
        end
      end
      DEQUEUE: begin
        if (line_q.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          s = line_q.pop_front();
          r.elem = s.elem;
        end
      end
      default: begin
        line_q.delete();
      end
    endcase
    return r;
  endfunction

  task automatic send_word(input logic [REQ_W-1:0] req, input logic [ELEM_W-1:0] elem,
                           input logic [TEAM_W-1:0] team, input logic typed,
                           input reply_t typed_reply);
    reply_t r;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    req_type_i   <= req;
    element_id_i <= elem;
    team_id_i    <= team;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = team_queue_reply(req, elem, team);
    owed_replies.push_back(typed ? typed_reply : r);
    n_req[req]++;
    if (r.status == ST_FULL) n_full++;
    if (r.status == ST_EMPTY) n_empty++;
    if (line_q.size() > peak_depth) peak_depth = line_q.size();
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (owed_replies.size() == 0) begin
        $display("%0t: unexpected word out_element %0d status %0d", $time,
                 out_element_o, status_o);
        errors++;
      end else begin
        want = owed_replies.pop_front();
        if (out_element_o !== want.elem) begin
          $display("%0t: out_element expected %0d actual %0d", $time, want.elem,
                   out_element_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, status_o);
          errors++;
        end
        replies_seen++;
      end
    end
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  initial begin
    step_t             directed [26];
    mode_e             plan [8];
    reply_t            tr;
    int                roll;
    logic [REQ_W-1:0]  req;
    logic [ELEM_W-1:0] elem;
    logic [TEAM_W-1:0] team;

    directed = '{
      '{DEQUEUE,    10'd0,    8'd0,   1'b1, 10'd0, ST_EMPTY},
      '{REQ_ASSIGN, 10'd1023, 8'd255, 1'b1, 10'd0, ST_OK},
      '{REQ_ASSIGN, 10'd512,  8'd128, 1'b0, 10'd0, ST_OK},
      '{ENQUEUE,    10'd1023, 8'd0,   1'b1, 10'd0, ST_OK},
      '{ENQUEUE,    10'd5,    8'd0,   1'b0, 10'd0, ST_OK},
      '{ENQUEUE,    10'd512,  8'd0,   1'b0, 10'd0, ST_OK},
      '{ENQUEUE,    10'd0,    8'd0,   1'b0, 10'd0, ST_OK},
      '{REQ_ASSIGN, 10'd7,    8'd255, 1'b0, 10'd0, ST_OK},
      '{ENQUEUE,    10'd7,    8'd0,   1'b0, 10'd0, ST_OK},
      '{REQ_ASSIGN, 10'd1023, 8'd1,   1'b0, 10'd0, ST_OK},
      '{ENQUEUE,    10'd9,    8'd0,   1'b0, 10'd0, ST_OK},
      '{DEQUEUE,    10'd0,    8'd0,   1'b0, 10'd0, ST_OK},
      '{ENQUEUE,    10'd1023, 8'd0,   1'b0, 10'd0, ST_OK},
      '{DEQUEUE,    10'd0,    8'd0,   1'b0, 10'd0, ST_OK},
      '{REQ_ASSIGN, 10'd300,  8'd255, 1'b0, 10'd0, ST_OK},
      '{ENQUEUE,    10'd300,  8'd0,   1'b0, 10'd0, ST_OK},
      '{DEQUEUE,    10'd0,    8'd0,   1'b0, 10'd0, ST_OK},
      '{DEQUEUE,    10'd0,    8'd0,   1'b0, 10'd0, ST_OK},
      '{DEQUEUE,    10'd0,    8'd0,   1'b0, 10'd0, ST_OK},
      '{ENQUEUE,    10'd0,    8'd0,   1'b0, 10'd0, ST_OK},
      '{REQ_CLEAR,  10'd0,    8'd0,   1'b1, 10'd0, ST_OK},
      '{DEQUEUE,    10'd0,    8'd0,   1'b1, 10'd0, ST_EMPTY},
      '{ENQUEUE,    10'd7,    8'd0,   1'b0, 10'd0, ST_OK},
      '{DEQUEUE,    10'd0,    8'd0,   1'b0, 10'd0, ST_OK},
      '{ENQUEUE,    10'd5,    8'd0,   1'b0, 10'd0, ST_OK},
      '{DEQUEUE,    10'd0,    8'd0,   1'b0, 10'd0, ST_OK}
    };
    plan = '{MODE_MIX, MODE_FILL, MODE_FILL, MODE_DRAIN,
             MODE_MIX, MODE_FILL, MODE_FILL, MODE_DRAIN};

    for (int i = 0; i < NELEM; i++) team_of[i] = '0;
    for (int i = 0; i < 4; i++) n_req[i] = 0;

    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[k]) begin
      tr.elem   = directed[k].exp_elem;
      tr.status = directed[k].exp_st;
      send_word(directed[k].req, directed[k].elem, directed[k].team, directed[k].typed, tr);
    end

    for (int ph = 0; ph < 8; ph++) begin
      case ((ph + ph / 4) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      for (int n = 0; n < PHASE_WORDS; n++) begin
        roll = $urandom_range(99);
        case (plan[ph])
          MODE_MIX: begin
            if (roll < 15) req = REQ_ASSIGN;
            else if (roll < 55) req = ENQUEUE;
            else if (roll < 98) req = DEQUEUE;
            else req = REQ_CLEAR;
          end
          MODE_FILL: begin
            if (roll < 10) req = REQ_ASSIGN;
            else if (roll < 96) req = ENQUEUE;
            else req = DEQUEUE;
          end
          default: begin
            if (roll < 5) req = REQ_ASSIGN;
            else if (roll < 15) req = ENQUEUE;
            else req = DEQUEUE;
          end
        endcase
        elem = ($urandom_range(99) < 60) ? ELEM_W'($urandom_range(31))
                                         : ELEM_W'($urandom_range(NELEM - 1));
        team = ($urandom_range(99) < 70) ? TEAM_W'($urandom_range(5))
                                         : TEAM_W'($urandom_range(255));
        send_word(req, elem, team, 1'b0, '0);
      end
    end
    in_valid_i <= 1'b0;

    while (owed_replies.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d words sent: %0d assign, %0d enqueue, %0d dequeue, %0d clear; %0d checked",
             n_req[REQ_ASSIGN] + n_req[ENQUEUE] + n_req[DEQUEUE] + n_req[REQ_CLEAR],
             n_req[REQ_ASSIGN], n_req[ENQUEUE], n_req[DEQUEUE], n_req[REQ_CLEAR],
             replies_seen);
    $display("full rejects %0d, empty dequeues %0d, peak depth %0d",
             n_full, n_empty, peak_depth);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
